/* hdl/mhq_pkg.sv */
// Shared constants, types and codes for the mutex handoff queue engine.
package mhq_pkg;

   // Field widths of the request and response transactions
   localparam int MUTEX_ID_W = 4;
   localparam int TASK_ID_W  = 6;
   localparam int STATUS_W   = 3;

   // Sizing
   localparam int MUTEX_COUNT  = 16;
   localparam int TASK_ID_BITS = 6;
   localparam int QUEUE_DEPTH  = 8;

   localparam int MUTEX_AW   = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
   localparam int QHW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW        = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOT_DEPTH = MUTEX_COUNT * QUEUE_DEPTH;
   localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

   typedef enum logic {
      OP_LOCK   = 1'b0,
      OP_UNLOCK = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACQUIRED = 3'd0,
      ST_BLOCKED  = 3'd1,
      ST_FREED    = 3'd2,
      ST_HANDED   = 3'd3,
      ST_IGNORED  = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_HAND
   } engine_state_type;

   // Per-mutex record kept in the state memory
   typedef struct packed {
      logic                    held;
      logic [TASK_ID_BITS-1:0] owner;
      logic [QHW-1:0]          head;
      logic [QCW-1:0]          count;
   } mutex_state_type;

   localparam int MSTATE_W = $bits(mutex_state_type);

   // Access command toward the mutex state store
   typedef struct packed {
      logic                rd_en;
      logic [MUTEX_AW-1:0] rd_addr;
      logic                wr_en;
      logic [MUTEX_AW-1:0] wr_addr;
      mutex_state_type     wr_data;
   } mstate_cmd_type;

endpackage

/* hdl/mhq_if.sv */
// Valid/ready channel interfaces for request and response transactions.
interface mhq_req_if import mhq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  op;
   logic [MUTEX_ID_W-1:0] mutex_id;
   logic [TASK_ID_W-1:0]  task_id;

   modport source (output valid, op, mutex_id, task_id, input ready);
   modport sink   (input valid, op, mutex_id, task_id, output ready);
endinterface

interface mhq_rsp_if import mhq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic                 woken_valid;
   logic [TASK_ID_W-1:0] woken_task;

   modport source (output valid, status, woken_valid, woken_task, input ready);
   modport sink   (input valid, status, woken_valid, woken_task, output ready);
endinterface

/* hdl/mhq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/mhq_state_store.sv */
// Mutex state memory with per-entry valid bits that read back as the reset record.
module mhq_state_store import mhq_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  mstate_cmd_type  cmd,
   output mutex_state_type rd_state
);

   logic [MUTEX_COUNT-1:0] valid_ff;
   logic [MUTEX_COUNT-1:0] valid_in;
   logic                   rd_valid_ff;
   logic                   rd_valid_in;
   logic [MSTATE_W-1:0]    rd_data;

   mhq_ram #(
      .WIDTH (MSTATE_W),
      .DEPTH (MUTEX_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   // Mark written entries, sample the valid bit alongside the read
   always_comb begin
      valid_in    = valid_ff;
      rd_valid_in = rd_valid_ff;
      if (cmd.wr_en) begin
         valid_in[cmd.wr_addr] = 1'b1;
      end
      if (cmd.rd_en) begin
         rd_valid_in = valid_ff[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // Never-written entries read as a free mutex with an empty queue
   assign rd_state = rd_valid_ff ? mutex_state_type'(rd_data) : '0;

endmodule

/* hdl/mutex_handoff_queue_engine.sv */
// Hardware mutex engine: owner tracking and FIFO wait queues held in on-chip memory.
// Each request reads its state memory entry, is evaluated, and gets a registered response;
// a handoff to a waiter adds a wait-slot read between evaluation and the response.
// One transaction at a time: each reads the state memory entry of its mutex, and writes
// it back where it changes, before the next request is taken.
// Reset: synchronous; all mutexes free and all queues empty at once, no sweep.
module mutex_handoff_queue_engine import mhq_pkg::*; (
   input logic     clock,
   input logic     reset,
   mhq_req_if.sink req,
   mhq_rsp_if.source rsp
);

   engine_state_type        state_ff, state_in;
   logic                    op_ff, op_in;
   logic [MUTEX_AW-1:0]     mutex_ff, mutex_in;
   logic [TASK_ID_BITS-1:0] task_ff, task_in;
   logic                    in_range_ff, in_range_in;
   mutex_state_type         hold_ff, hold_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              status_ff, status_in;
   logic                    woken_valid_ff, woken_valid_in;
   logic [TASK_ID_W-1:0]    woken_task_ff, woken_task_in;

   mstate_cmd_type          cmd;
   mutex_state_type         cur;

   logic                    slot_wr_en;
   logic [SLOT_AW-1:0]      slot_wr_addr;
   logic                    slot_rd_en;
   logic [SLOT_AW-1:0]      slot_rd_addr;
   logic [TASK_ID_BITS-1:0] slot_rd_data;

   logic                    accept;
   logic                    out_free;
   logic [SLOT_AW-1:0]      slot_base;
   logic [QCW:0]            pos_sum;
   logic [QHW-1:0]          tail_pos;
   logic [QHW-1:0]          head_next;
   logic [TASK_ID_BITS-1:0] next_owner;

   mhq_state_store u_state (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_state (cur)
   );

   mhq_ram #(
      .WIDTH (TASK_ID_BITS),
      .DEPTH (SLOT_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (task_ff),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // Queue slot arithmetic for the mutex in flight
   always_comb begin
      slot_base = SLOT_AW'(mutex_ff) * SLOT_AW'(QUEUE_DEPTH);
      pos_sum   = (QCW+1)'(cur.head) + (QCW+1)'(cur.count);
      if (pos_sum >= (QCW+1)'(QUEUE_DEPTH)) begin
         tail_pos = QHW'(pos_sum - (QCW+1)'(QUEUE_DEPTH));
      end else begin
         tail_pos = QHW'(pos_sum);
      end
      if (hold_ff.head == QHW'(QUEUE_DEPTH - 1)) begin
         head_next = '0;
      end else begin
         head_next = hold_ff.head + 1'b1;
      end
      next_owner = slot_rd_data;
   end

   // Sequence one transaction: read state, decide, write back, post response
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      mutex_in       = mutex_ff;
      task_in        = task_ff;
      in_range_in    = in_range_ff;
      hold_in        = hold_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      status_in      = status_ff;
      woken_valid_in = woken_valid_ff;
      woken_task_in  = woken_task_ff;
      req.ready      = 1'b0;
      cmd            = '0;
      cmd.wr_addr    = mutex_ff;
      slot_wr_en     = 1'b0;
      slot_wr_addr   = slot_base + SLOT_AW'(tail_pos);
      slot_rd_en     = 1'b0;
      slot_rd_addr   = slot_base + SLOT_AW'(cur.head);

      case (state_ff)
         S_IDLE: begin
            req.ready   = 1'b1;
            cmd.rd_addr = MUTEX_AW'(req.mutex_id);
            if (accept) begin
               cmd.rd_en   = 1'b1;
               op_in       = req.op;
               mutex_in    = MUTEX_AW'(req.mutex_id);
               task_in     = req.task_id[TASK_ID_BITS-1:0];
               in_range_in = (32'(req.mutex_id) < MUTEX_COUNT);
               state_in    = S_EVAL;
            end
         end

         S_EVAL: begin
            hold_in = cur;
            if (in_range_ff && op_ff == OP_UNLOCK && cur.held && cur.owner == task_ff
                && cur.count != '0) begin
               // Fetch the oldest waiter
               slot_rd_en = 1'b1;
               state_in   = S_HAND;
            end else if (out_free) begin
               rsp_valid_in   = 1'b1;
               woken_valid_in = 1'b0;
               woken_task_in  = '0;
               state_in       = S_IDLE;
               cmd.wr_data    = cur;
               if (!in_range_ff) begin
                  status_in = (op_ff == OP_UNLOCK) ? ST_IGNORED : ST_FULL;
               end else if (op_ff == OP_LOCK) begin
                  if (!cur.held) begin
                     cmd.wr_en         = 1'b1;
                     cmd.wr_data.held  = 1'b1;
                     cmd.wr_data.owner = task_ff;
                     status_in         = ST_ACQUIRED;
                  end else if (cur.count >= QCW'(QUEUE_DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     slot_wr_en        = 1'b1;
                     cmd.wr_en         = 1'b1;
                     cmd.wr_data.count = cur.count + 1'b1;
                     status_in         = ST_BLOCKED;
                  end
               end else begin
                  if (!cur.held || cur.owner != task_ff) begin
                     status_in = ST_IGNORED;
                  end else begin
                     cmd.wr_en         = 1'b1;
                     cmd.wr_data.held  = 1'b0;
                     cmd.wr_data.owner = '0;
                     status_in         = ST_FREED;
                  end
               end
            end
         end

         S_HAND: begin
            if (out_free) begin
               cmd.wr_en         = 1'b1;
               cmd.wr_data       = hold_ff;
               cmd.wr_data.owner = next_owner;
               cmd.wr_data.head  = head_next;
               cmd.wr_data.count = hold_ff.count - 1'b1;
               rsp_valid_in      = 1'b1;
               status_in         = ST_HANDED;
               woken_valid_in    = 1'b1;
               woken_task_in     = TASK_ID_W'(next_owner);
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold transaction fields and response payload
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      mutex_ff       <= mutex_in;
      task_ff        <= task_in;
      in_range_ff    <= in_range_in;
      hold_ff        <= hold_in;
      status_ff      <= status_in;
      woken_valid_ff <= woken_valid_in;
      woken_task_ff  <= woken_task_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.woken_valid = woken_valid_ff;
   assign rsp.woken_task  = woken_task_ff;

   // An accepted transaction always moves on to evaluation
   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EVAL)
      else $error("accepted transaction did not enter evaluation");

   // Handoff is only reached from evaluation
   a_hand_from_eval: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HAND |-> ($past(state_ff) == S_EVAL || $past(state_ff) == S_HAND))
      else $error("handoff entered without evaluation");

   // Written queue occupancy never exceeds the queue depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> cmd.wr_data.count <= QCW'(QUEUE_DEPTH))
      else $error("queue count overflow written");

   // Woken flag accompanies exactly the handoff status
   a_woken_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (woken_valid_ff == (status_ff == ST_HANDED)))
      else $error("woken flag disagrees with status");

endmodule
